FILE: sv/fumb_pkg.sv
package fumb_pkg;

    // Byte that closes the character list of one glyph
    localparam logic [7:0] GLYPH_SEP = 8'hFF;

    // Field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CODE_W    = 16;
    localparam int unsigned GLYPH_W   = 16;
    localparam int unsigned PENDING_W = 2;

    // Continuation bytes still expected after each kind of lead
    localparam logic [PENDING_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PENDING_W-1:0] PEND_ONE   = 2'd1;
    localparam logic [PENDING_W-1:0] PEND_TWO   = 2'd2;
    localparam logic [PENDING_W-1:0] PEND_THREE = 2'd3;

    // One decoded table write, with a flag saying whether the byte produced one
    typedef struct packed {
        logic               emit;
        logic [CODE_W-1:0]  code_point;
        logic [GLYPH_W-1:0] glyph_index;
    } map_word_t;

endpackage

FILE: sv/fumb_if.sv
interface fumb_byte_if;
    logic                          valid;
    logic                          ready;
    logic [fumb_pkg::BYTE_W-1:0]   in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface fumb_map_if;
    logic                          valid;
    logic                          ready;
    logic [fumb_pkg::CODE_W-1:0]   code_point;
    logic [fumb_pkg::GLYPH_W-1:0]  glyph_index;

    modport source (output valid, output code_point, output glyph_index, input ready);
    modport sink   (input valid, input code_point, input glyph_index, output ready);
endinterface

FILE: sv/fumb_decoder.sv
module fumb_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [fumb_pkg::BYTE_W-1:0]         in_byte,
    output fumb_pkg::map_word_t                 result
);

    logic [fumb_pkg::GLYPH_W-1:0]   glyph_count_reg;
    logic [fumb_pkg::GLYPH_W-1:0]   glyph_count_next;
    logic [fumb_pkg::CODE_W-1:0]    partial_code_reg;
    logic [fumb_pkg::CODE_W-1:0]    partial_code_next;
    logic [fumb_pkg::PENDING_W-1:0] bytes_pending_reg;
    logic [fumb_pkg::PENDING_W-1:0] bytes_pending_next;

    // Decode one byte against the current sequence state
    always_comb
    begin
        glyph_count_next   = glyph_count_reg;
        partial_code_next  = partial_code_reg;
        bytes_pending_next = bytes_pending_reg;
        result.emit        = 1'b0;
        result.code_point  = partial_code_reg;
        result.glyph_index = glyph_count_reg;

        if (bytes_pending_reg != fumb_pkg::PEND_NONE)
        begin
            // Shift in six payload bits; top two bits of the byte are ignored
            partial_code_next  = {partial_code_reg[fumb_pkg::CODE_W-7:0], in_byte[5:0]};
            bytes_pending_next = bytes_pending_reg - fumb_pkg::PEND_ONE;
            result.code_point  = partial_code_next;
            result.emit        = (bytes_pending_reg == fumb_pkg::PEND_ONE);
        end
        else if (in_byte == fumb_pkg::GLYPH_SEP)
        begin
            glyph_count_next = glyph_count_reg + 1'b1;
        end
        else if (!in_byte[7])
        begin
            result.emit       = 1'b1;
            result.code_point = {{(fumb_pkg::CODE_W-fumb_pkg::BYTE_W){1'b0}}, in_byte};
        end
        else if (!in_byte[5])
        begin
            partial_code_next  = {{(fumb_pkg::CODE_W-5){1'b0}}, in_byte[4:0]};
            bytes_pending_next = fumb_pkg::PEND_ONE;
        end
        else if (!in_byte[4])
        begin
            partial_code_next  = {{(fumb_pkg::CODE_W-4){1'b0}}, in_byte[3:0]};
            bytes_pending_next = fumb_pkg::PEND_TWO;
        end
        else if (!in_byte[3])
        begin
            partial_code_next  = {{(fumb_pkg::CODE_W-3){1'b0}}, in_byte[2:0]};
            bytes_pending_next = fumb_pkg::PEND_THREE;
        end
        else
        begin
            // Over-long lead: stands for code zero at once
            result.emit       = 1'b1;
            result.code_point = '0;
        end
    end

    // Advance sequence state only when the byte is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_count_reg   <= '0;
            partial_code_reg  <= '0;
            bytes_pending_reg <= fumb_pkg::PEND_NONE;
        end
        else if (step)
        begin
            glyph_count_reg   <= glyph_count_next;
            partial_code_reg  <= partial_code_next;
            bytes_pending_reg <= bytes_pending_next;
        end
    end

endmodule

FILE: sv/fumb_out_reg.sv
module fumb_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  fumb_pkg::map_word_t result,
    output logic                free,
    fumb_map_if.source          map
);

    logic                         valid_reg;
    logic [fumb_pkg::CODE_W-1:0]  code_point_reg;
    logic [fumb_pkg::GLYPH_W-1:0] glyph_index_reg;

    // Room for a new word when empty or when the held word leaves this cycle
    assign free = !valid_reg || map.ready;

    // Hold the result word until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load && result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load && result.emit)
        begin
            code_point_reg  <= result.code_point;
            glyph_index_reg <= result.glyph_index;
        end
    end

    assign map.valid       = valid_reg;
    assign map.code_point  = code_point_reg;
    assign map.glyph_index = glyph_index_reg;

endmodule

FILE: sv/font_unicode_map_builder_top.sv
// Unicode table decoder for bitmap fonts.
// The bytes channel takes one raw byte of the font's unicode table per word.
// The map channel gives one table write per completed character: the code
// point (low 16 bits) and the glyph number it belongs to.
// Byte 0xFF outside a sequence moves on to the next glyph and gives no word;
// lead and continuation bytes of a multi-byte character give no word until
// the last one arrives.
// Throughput: one byte per cycle while the map receiver does not stall, set by
// the single decode step between the input register and the result register.
// A byte in the input register is decoded when the result register has room,
// and its word is then held there and offered on the map channel.
// Reset clears the glyph counter, the partial code and the pending count,
// and empties both registers.
// When the receiver stalls, the held word stays put; the byte in the input
// register waits, and the bytes channel stays ready only while that
// register is empty.
module font_unicode_map_builder_top (
    input  logic        clk,
    input  logic        rst_n,
    fumb_byte_if.sink   bytes,
    fumb_map_if.source  map
);

    logic                        in_valid_reg;
    logic [fumb_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        out_free;
    logic                        advance;
    fumb_pkg::map_word_t         result;

    // Decode the held byte when the result register can take its word
    assign advance     = in_valid_reg && out_free;
    assign bytes.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            in_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            in_byte_reg <= bytes.in_byte;
        end
    end

    fumb_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .in_byte (in_byte_reg),
        .result  (result)
    );

    fumb_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .free   (out_free),
        .map    (map)
    );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    // One entry of the byte plan: either a byte to send or a pause marker
    typedef struct {
        bit                          pause;
        logic [fumb_pkg::BYTE_W-1:0] b;
    } plan_entry_t;

    logic clk;
    logic rst_n;

    fumb_byte_if bytes_ch ();
    fumb_map_if  map_ch ();

    font_unicode_map_builder_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes_ch),
        .map   (map_ch)
    );

    // Decoder state as seen by the predictor
    logic [fumb_pkg::GLYPH_W-1:0]   glyph_ctr;
    logic [fumb_pkg::CODE_W-1:0]    part_code;
    logic [fumb_pkg::PENDING_W-1:0] pend_cnt;

    plan_entry_t         byte_plan [$];
    fumb_pkg::map_word_t map_expect_q [$];

    int unsigned plan_bytes;
    int unsigned sent_cnt;
    int unsigned recv_cnt;
    int unsigned errors;
    int unsigned hold_left;
    bit          hold_done;

    // Driver scratch
    fumb_pkg::map_word_t drv_word;
    plan_entry_t         drv_next;
    bit                  drv_busy;

    // Monitor scratch
    fumb_pkg::map_word_t mon_word;

    always #6 clk = ~clk;

    // Work out the table write caused by one byte of the unicode table
    function automatic fumb_pkg::map_word_t decode_table_byte(
        input logic [fumb_pkg::BYTE_W-1:0] b);
        fumb_pkg::map_word_t w;
        w = '0;
        if (pend_cnt != fumb_pkg::PEND_NONE) begin
            // Shift in six payload bits; the top two bits of the byte are ignored
            part_code = {part_code[fumb_pkg::CODE_W-7:0], b[5:0]};
            pend_cnt  = pend_cnt - 1'b1;
            if (pend_cnt == fumb_pkg::PEND_NONE) begin
                w.emit        = 1'b1;
                w.code_point  = part_code;
                w.glyph_index = glyph_ctr;
            end
        end else if (b == fumb_pkg::GLYPH_SEP) begin
            glyph_ctr = glyph_ctr + 1'b1;
        end else if (!b[7]) begin
            w.emit        = 1'b1;
            w.code_point  = {8'h00, b};
            w.glyph_index = glyph_ctr;
        end else if (!b[5]) begin
            part_code = {11'd0, b[4:0]};
            pend_cnt  = fumb_pkg::PEND_ONE;
        end else if (!b[4]) begin
            part_code = {12'd0, b[3:0]};
            pend_cnt  = fumb_pkg::PEND_TWO;
        end else if (!b[3]) begin
            part_code = {13'd0, b[2:0]};
            pend_cnt  = fumb_pkg::PEND_THREE;
        end else begin
            // Leads 0xF8..0xFE stand for code 0
            w.emit        = 1'b1;
            w.code_point  = '0;
            w.glyph_index = glyph_ctr;
        end
        return w;
    endfunction

    task automatic push_byte(input logic [fumb_pkg::BYTE_W-1:0] b);
        plan_entry_t e;
        e.pause = 1'b0;
        e.b     = b;
        byte_plan.push_back(e);
        plan_bytes++;
    endtask

    task automatic push_pause();
        plan_entry_t e;
        e.pause = 1'b1;
        e.b     = '0;
        byte_plan.push_back(e);
    endtask

    // Append continuation bytes, now and then a malformed one
    task automatic push_cont(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                push_byte(8'($urandom_range(0, 255)));
            else
                push_byte(8'(8'h80 + $urandom_range(0, 63)));
        end
    endtask

    // Bytes side: offer the plan, feed the predictor on every accepted word
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bytes_ch.valid   <= 1'b0;
            bytes_ch.in_byte <= '0;
            glyph_ctr = '0;
            part_code = '0;
            pend_cnt  = fumb_pkg::PEND_NONE;
        end else begin
            drv_busy = bytes_ch.valid;
            if (bytes_ch.valid && bytes_ch.ready) begin
                drv_word = decode_table_byte(bytes_ch.in_byte);
                if (drv_word.emit)
                    map_expect_q.push_back(drv_word);
                sent_cnt++;
                drv_busy = 1'b0;
            end
            if (!drv_busy) begin
                // Drop a pause marker once the map channel has drained
                if (byte_plan.size() > 0 && byte_plan[0].pause && map_expect_q.size() == 0)
                    void'(byte_plan.pop_front());
                if (byte_plan.size() > 0 && !byte_plan[0].pause &&
                    ((sent_cnt >= 400 && sent_cnt < 700) || $urandom_range(0, 99) >= 14)) begin
                    drv_next = byte_plan.pop_front();
                    bytes_ch.in_byte <= drv_next.b;
                    bytes_ch.valid   <= 1'b1;
                end else begin
                    bytes_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Map side: check each word against the oldest expectation, stall at random
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            map_ch.ready <= 1'b0;
        end else begin
            if (map_ch.valid && map_ch.ready) begin
                if (map_expect_q.size() == 0) begin
                    $display("%0t: unexpected word code_point=%h glyph_index=%h",
                             $time, map_ch.code_point, map_ch.glyph_index);
                    errors++;
                end else begin
                    mon_word = map_expect_q.pop_front();
                    if (map_ch.code_point !== mon_word.code_point) begin
                        $display("%0t: code_point expected %h actual %h",
                                 $time, mon_word.code_point, map_ch.code_point);
                        errors++;
                    end
                    if (map_ch.glyph_index !== mon_word.glyph_index) begin
                        $display("%0t: glyph_index expected %h actual %h",
                                 $time, mon_word.glyph_index, map_ch.glyph_index);
                        errors++;
                    end
                end
                recv_cnt++;
            end
            // Hold off once for a long stretch so the block backs up
            if (hold_left > 0) begin
                hold_left--;
                map_ch.ready <= 1'b0;
            end else if (!hold_done && recv_cnt == 150) begin
                hold_done = 1'b1;
                hold_left = 300;
                map_ch.ready <= 1'b0;
            end else begin
                map_ch.ready <= (recv_cnt >= 200 && recv_cnt < 350) ||
                                ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // Stimulus plan, reset and end of run
    initial begin
        int unsigned rand_start;
        int unsigned kind;
        bit          mid_paused;

        clk              = 1'b0;
        rst_n            = 1'b0;
        plan_bytes       = 0;
        sent_cnt         = 0;
        recv_cnt         = 0;
        errors           = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        mid_paused       = 1'b0;

        // Directed: single bytes at both ends, glyph advance
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(fumb_pkg::GLYPH_SEP);
        // Two, three and four byte characters; the last one is longer than 16 bits
        push_byte(8'hC3); push_byte(8'hA9);
        push_byte(8'hE2); push_byte(8'h82); push_byte(8'hAC);
        push_byte(8'hF0); push_byte(8'h9F); push_byte(8'h98); push_byte(8'h80);
        // Leads that stand for code 0
        push_byte(8'hF8);
        push_byte(8'hFE);
        // Continuation bytes as leads, one of them with a bad continuation
        push_byte(8'h80); push_byte(8'h41);
        push_byte(8'hBF); push_byte(8'h00); push_byte(8'hFF);
        // Separator inside a sequence
        push_byte(8'hDF); push_byte(fumb_pkg::GLYPH_SEP);
        push_byte(fumb_pkg::GLYPH_SEP);
        push_byte(8'h20);
        push_pause();

        // Random: mostly well-formed characters with random payload
        rand_start = plan_bytes;
        while (plan_bytes - rand_start < 1000) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                push_byte(8'($urandom_range(0, 127)));
            end else if (kind < 40) begin
                push_byte(fumb_pkg::GLYPH_SEP);
            end else if (kind < 55) begin
                push_byte(8'(8'hC0 + $urandom_range(0, 31)));
                push_cont(1);
            end else if (kind < 70) begin
                push_byte(8'(8'hE0 + $urandom_range(0, 15)));
                push_cont(2);
            end else if (kind < 80) begin
                push_byte(8'(8'hF0 + $urandom_range(0, 7)));
                push_cont(3);
            end else if (kind < 85) begin
                push_byte(8'(8'hF8 + $urandom_range(0, 7)));
            end else begin
                push_byte(8'($urandom_range(0, 255)));
            end
            if (!mid_paused && plan_bytes - rand_start >= 500) begin
                mid_paused = 1'b1;
                push_pause();
            end
        end

        // Close any open sequence, then move on a few glyphs
        push_byte(8'h41); push_byte(8'h42); push_byte(8'h43);
        push_pause();
        for (int i = 0; i < 4; i++)
            push_byte(fumb_pkg::GLYPH_SEP);
        push_byte(8'h44);
        push_byte(fumb_pkg::GLYPH_SEP);
        push_byte(8'h45);
        // Leave the stream inside a sequence
        push_byte(8'hE0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until the plan is used up and every word has come back
        while (byte_plan.size() > 0 || bytes_ch.valid || map_expect_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #(12 * 600000);
        $display("tb: FAIL");
        $finish;
    end

endmodule
